@@ rtl/key_matrix_debounce_hold_assert.svh @@
// Assertion macros shared by the key matrix debounce checker.
`ifndef KEY_MATRIX_DEBOUNCE_HOLD_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCE_HOLD_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define KMDH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define KMDH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define KMDH_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/kmdh_pkg.sv @@
// Constants and types shared by the key matrix debounce block and its checker.
package kmdh_pkg;

  // Matrix geometry and the one unconnected position.
  localparam int ROWS      = 3;
  localparam int COLS      = 4;
  localparam int KEY_COUNT = ROWS * COLS;
  localparam int KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int GAP_ROW   = 1;
  localparam int GAP_COL   = 3;

  // Field widths.
  localparam int ROW_W   = 2;
  localparam int COL_W   = 2;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 16;

  // Register reset values.
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd10;
  localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd500;

  // Register indexes on the configuration port.
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_DEBOUNCE_MS    = 1'b0;
  localparam cfg_index_t REG_HOLD_THRESHOLD = 1'b1;

  // Input item layout in s_tdata.
  localparam int IN_ROW_LSB    = 0;
  localparam int IN_COL_LSB    = IN_ROW_LSB + ROW_W;
  localparam int IN_RAW_BIT    = IN_COL_LSB + COL_W;
  localparam int IN_NOW_LSB    = IN_RAW_BIT + 1;
  localparam int IN_FIELDS_W   = IN_NOW_LSB + TIME_W;
  localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;

  // Result item layout in m_tdata; key_valid travels in m_tuser.
  localparam int OUT_PRESSED_BIT = 0;
  localparam int OUT_EDGE_BIT    = 1;
  localparam int OUT_HELD_BIT    = 2;
  localparam int OUT_COUNT_LSB   = 3;
  localparam int OUT_FIELDS_W    = OUT_COUNT_LSB + COUNT_W;
  localparam int OUT_DATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [KEY_IDX_W-1:0] key_idx_t;

endpackage

@@ rtl/key_matrix_debounce_hold.sv @@
// Debounced key matrix: per-key pressed state, press edge, hold count and held flag.
//
// Usage:
//   s_* carries one sample item: row, column, active-low raw level and the
//   current millisecond time. m_* returns one result item per sample:
//   key_valid in m_tuser, pressed/press_edge/held/hold_count in m_tdata.
//   cfg_* writes debounce_ms (index 0) and hold_threshold (index 1); it is
//   always ready. The user must write it only while no item is in flight;
//   the block itself does not enforce this. A sample accepted on s_* moves
//   through the input register, then the result register, to m_*.
// Throughput: one item per cycle unless stalled. The per-key state is read,
//   updated and written back in the same single pass that loads the result
//   register, so a following sample of the same key sees the updated state.
// Reset: rst (synchronous) clears all per-key state, restores both registers
//   to 10 ms and 500, and empties both pipeline registers.
// Stall: while m_tready is low the result holds; one further sample waits in
//   the input register, after which s_tready drops until the result is taken.
module key_matrix_debounce_hold (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata fields from bit 0: row[1:0], column[3:2], raw_level[4], now_ms[36:5]
  input  logic [kmdh_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // m_tdata fields from bit 0: pressed[0], press_edge[1], held[2], hold_count[34:3]
  output logic [kmdh_pkg::OUT_DATA_W-1:0]   m_tdata,
  // m_tuser fields from bit 0: key_valid[0]
  output logic [0:0]                        m_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  kmdh_pkg::cfg_index_t              cfg_index,
  input  logic [kmdh_pkg::CFG_W-1:0]        cfg_data
);
  import kmdh_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] debounce_ms;
  logic [CFG_W-1:0] hold_threshold;

  // Per-key state.
  logic               key_down     [KEY_COUNT];
  logic [TIME_W-1:0]  press_time   [KEY_COUNT];
  logic [TIME_W-1:0]  release_time [KEY_COUNT];
  logic [COUNT_W-1:0] hold_counter [KEY_COUNT];

  // Input register.
  logic              in_valid;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_column;
  logic              in_raw_level;
  logic [TIME_W-1:0] in_now;

  // Result register.
  logic               out_valid;
  logic               out_key_valid;
  logic               out_pressed;
  logic               out_edge;
  logic               out_held;
  logic [COUNT_W-1:0] out_hold_count;

  // Update logic.
  logic               advance;
  logic               pos_ok;
  key_idx_t           key_idx;
  logic               cur_down;
  logic [COUNT_W-1:0] cur_count;
  logic               now_pressed;
  logic [TIME_W-1:0]  since;
  logic               take;
  logic               down_next;
  logic               edge_next;
  logic [COUNT_W-1:0] count_next;
  logic [TIME_W-1:0]  press_time_next;
  logic [TIME_W-1:0]  release_time_next;
  logic               held_next;

  // Handshake: the input register drains whenever the result register can load.
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms    <= DEBOUNCE_RESET;
      hold_threshold <= HOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE_MS:    debounce_ms    <= cfg_data;
        REG_HOLD_THRESHOLD: hold_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_row       <= s_tdata[IN_ROW_LSB +: ROW_W];
      in_column    <= s_tdata[IN_COL_LSB +: COL_W];
      in_raw_level <= s_tdata[IN_RAW_BIT];
      in_now       <= s_tdata[IN_NOW_LSB +: TIME_W];
    end
  end

  // Position check and key index; an unconnected position reads entry zero.
  always_comb begin
    pos_ok = (int'(in_row) < ROWS) && (int'(in_column) < COLS) &&
             !((int'(in_row) == GAP_ROW) && (int'(in_column) == GAP_COL));
    key_idx = pos_ok ? key_idx_t'(int'(in_row) * COLS + int'(in_column)) : '0;
  end

  // Debounce test and next per-key state.
  always_comb begin
    cur_down    = key_down[key_idx];
    cur_count   = hold_counter[key_idx];
    now_pressed = !in_raw_level;
    since       = in_now - (now_pressed ? release_time[key_idx] : press_time[key_idx]);
    take        = (now_pressed == cur_down) || (since >= TIME_W'(debounce_ms));

    down_next         = cur_down;
    edge_next         = 1'b0;
    count_next        = cur_count;
    press_time_next   = press_time[key_idx];
    release_time_next = release_time[key_idx];
    if (take) begin
      down_next = now_pressed;
      edge_next = !cur_down && now_pressed;
      if (now_pressed) begin
        if (cur_count == '0) begin
          press_time_next = in_now;
        end
        if (cur_count != '1) begin
          count_next = cur_count + COUNT_W'(1);
        end
      end else begin
        release_time_next = in_now;
        count_next        = '0;
      end
    end
    held_next = down_next && (count_next > COUNT_W'(hold_threshold));
  end

  // Per-key state write-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        key_down[i]     <= 1'b0;
        press_time[i]   <= '0;
        release_time[i] <= '0;
        hold_counter[i] <= '0;
      end
    end else if (advance && pos_ok) begin
      key_down[key_idx]     <= down_next;
      press_time[key_idx]   <= press_time_next;
      release_time[key_idx] <= release_time_next;
      hold_counter[key_idx] <= count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_key_valid  <= pos_ok;
      out_pressed    <= pos_ok && down_next;
      out_edge       <= pos_ok && edge_next;
      out_held       <= pos_ok && held_next;
      out_hold_count <= pos_ok ? count_next : '0;
    end
  end

  // Output packing.
  assign m_tvalid   = out_valid;
  assign m_tuser[0] = out_key_valid;
  assign m_tdata    = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_hold_count,
                       out_held, out_edge, out_pressed};

endmodule

@@ rtl/kmdh_checker.sv @@
// Port-level checker for the key matrix debounce block, bound to its top level.
`include "key_matrix_debounce_hold_assert.svh"

module kmdh_checker (
  input logic                            clk,
  input logic                            rst,
  input logic [kmdh_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [0:0]                      m_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready
);
  import kmdh_pkg::*;

  logic               pressed;
  logic               press_edge;
  logic               held;
  logic [COUNT_W-1:0] hold_count;

  assign pressed    = m_tdata[OUT_PRESSED_BIT];
  assign press_edge = m_tdata[OUT_EDGE_BIT];
  assign held       = m_tdata[OUT_HELD_BIT];
  assign hold_count = m_tdata[OUT_COUNT_LSB +: COUNT_W];

  // A reset leaves no result item pending.
  `KMDH_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid, "result valid after reset")

  // A stalled result item holds its contents.
  `KMDH_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // An unconnected position reports an all-zero result.
  `KMDH_ASSERT_IMPLY(a_gap_zero, clk, rst, m_tvalid && !m_tuser[0], m_tdata == '0, "unconnected key gave nonzero result")

  // A press edge is a pressed key whose hold count has just started at one.
  `KMDH_ASSERT_IMPLY(a_edge_start, clk, rst, m_tvalid && press_edge, pressed && (hold_count == COUNT_W'(1)), "press edge without fresh hold count")

  // A held key is pressed and has counted at least once.
  `KMDH_ASSERT_IMPLY(a_held_pressed, clk, rst, m_tvalid && held, pressed && (hold_count != '0), "held without a pressed count")

endmodule

bind key_matrix_debounce_hold kmdh_checker u_kmdh_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

@@ tb/sv/key_matrix_debounce_hold_test.sv @@
// Self-checking testbench for the debounced key matrix: directed samples, then random scans.
module key_matrix_debounce_hold_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kmdh_pkg::*;

  // Cycles without any accepted item before the run is declared hung.
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 250;
  localparam int PHASE_COUNT = 6;
  localparam int DIRECTED_COUNT = 16;

  // One result item as the block reports it.
  typedef struct packed {
    logic               key_valid;
    logic               pressed;
    logic               press_edge;
    logic               held;
    logic [COUNT_W-1:0] hold_count;
  } key_report_t;

  // One directed sample; typed marks rows whose result is written out by hand.
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic              raw;
    logic [TIME_W-1:0] now;
    logic              typed;
    key_report_t       report;
  } sample_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_index_t            cfg_index = REG_DEBOUNCE_MS;
  logic [CFG_W-1:0]      cfg_data = '0;

  // Predicted per-key state and register copies.
  logic               key_is_down     [KEY_COUNT];
  logic [TIME_W-1:0]  last_press_ms   [KEY_COUNT];
  logic [TIME_W-1:0]  last_release_ms [KEY_COUNT];
  logic [COUNT_W-1:0] hold_total      [KEY_COUNT];
  logic [CFG_W-1:0]   debounce_setting = DEBOUNCE_RESET;
  logic [CFG_W-1:0]   hold_setting = HOLD_RESET;

  key_report_t pending_reports [$];
  int          failures = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 6;
  int          take_idle_pct = 64;

  // Directed samples with the block at its reset settings (10 ms, 500).
  sample_row_t directed_rows [DIRECTED_COUNT] = '{
    // Released reading on a released key is simply accepted.
    '{2'd0, 2'd0, 1'b1, 32'd0, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 32'd0}},
    // The gap position and rows past the matrix report an unconnected key.
    '{2'd1, 2'd3, 1'b0, 32'd100, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{2'd3, 2'd0, 1'b0, 32'd100, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{2'd3, 2'd3, 1'b1, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{2'd1, 2'd3, 1'b1, 32'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
    // Press too soon after the reset release is rejected, then accepted at 10 ms.
    '{2'd2, 2'd3, 1'b0, 32'd5, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{2'd2, 2'd3, 1'b0, 32'd10, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 32'd1}},
    '{2'd2, 2'd3, 1'b0, 32'd11, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 32'd2}},
    // Early release is rejected, a release 10 ms after the press clears the count.
    '{2'd2, 2'd3, 1'b1, 32'd15, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 32'd2}},
    '{2'd2, 2'd3, 1'b1, 32'd20, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 32'd0}},
    // Time differences across the 32-bit wrap, then presses at large times.
    '{2'd0, 2'd3, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
    '{2'd0, 2'd3, 1'b1, 32'd8, 1'b0, '0},
    '{2'd0, 2'd3, 1'b1, 32'd9, 1'b0, '0},
    '{2'd2, 2'd0, 1'b0, 32'h1234_5678, 1'b0, '0},
    '{2'd2, 2'd0, 1'b0, 32'h1234_5679, 1'b0, '0},
    '{2'd1, 2'd2, 1'b0, 32'h8000_0000, 1'b0, '0}
  };

  key_matrix_debounce_hold dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Debounce one sample against the predicted key state and return its report.
  function automatic key_report_t predict_report(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] column,
                                                 input logic raw,
                                                 input logic [TIME_W-1:0] now);
    key_report_t rep;
    int unsigned k;
    logic        want_down;
    logic        take;
    logic [TIME_W-1:0] since;
    rep = '0;
    if (row >= ROWS || column >= COLS || (row == GAP_ROW && column == GAP_COL))
      return rep;
    k = row * COLS + column;
    want_down = !raw;
    take = 1'b1;
    // A change of state needs debounce_ms since the opposite edge.
    if (want_down != key_is_down[k]) begin
      since = now - (want_down ? last_release_ms[k] : last_press_ms[k]);
      if (since < debounce_setting)
        take = 1'b0;
    end
    if (take) begin
      rep.press_edge = !key_is_down[k] && want_down;
      key_is_down[k] = want_down;
      if (want_down) begin
        if (hold_total[k] == '0)
          last_press_ms[k] = now;
        if (hold_total[k] != '1)
          hold_total[k] = hold_total[k] + 1'b1;
      end else begin
        last_release_ms[k] = now;
        hold_total[k] = '0;
      end
    end
    rep.key_valid  = 1'b1;
    rep.pressed    = key_is_down[k];
    rep.held       = key_is_down[k] && (hold_total[k] > hold_setting);
    rep.hold_count = hold_total[k];
    return rep;
  endfunction

  // Offer one sample item and record its expected report once it is accepted.
  task automatic push_sample(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] column,
                             input logic raw, input logic [TIME_W-1:0] now,
                             input logic typed, input key_report_t typed_report);
    logic [IN_DATA_W-1:0] word;
    key_report_t rep;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    word = '0;
    word[IN_ROW_LSB +: ROW_W]  = row;
    word[IN_COL_LSB +: COL_W]  = column;
    word[IN_RAW_BIT]           = raw;
    word[IN_NOW_LSB +: TIME_W] = now;
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    rep = predict_report(row, column, raw, now);
    if (typed)
      rep = typed_report;
    pending_reports.push_back(rep);
  endtask

  // Write both registers back to back.
  task automatic write_settings(input logic [CFG_W-1:0] debounce,
                                input logic [CFG_W-1:0] hold);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DEBOUNCE_MS;
    cfg_data  <= debounce;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    debounce_setting = debounce;
    cfg_index <= REG_HOLD_THRESHOLD;
    cfg_data  <= hold;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    hold_setting = hold;
    cfg_valid <= 1'b0;
  endtask

  // Hold the input side until every report is back and the pipeline is empty.
  task automatic wait_drained();
    while (pending_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                             input logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  // Result side: random back-pressure.
  always @(posedge clk)
    m_tready <= ($urandom_range(0, 99) >= take_idle_pct);

  // Compare each accepted result item with the oldest expected report.
  always @(posedge clk) begin : check_reports
    key_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result item: key_valid %0d, hold_count %0d",
               m_tuser[0], m_tdata[OUT_COUNT_LSB +: COUNT_W]);
        failures++;
      end else begin
        want = pending_reports.pop_front();
        check_field("key_valid", want.key_valid, m_tuser[0]);
        check_field("pressed", want.pressed, m_tdata[OUT_PRESSED_BIT]);
        check_field("press_edge", want.press_edge, m_tdata[OUT_EDGE_BIT]);
        check_field("held", want.held, m_tdata[OUT_HELD_BIT]);
        check_field("hold_count", want.hold_count, m_tdata[OUT_COUNT_LSB +: COUNT_W]);
      end
    end
  end

  // Watchdog on cycles in which no item moves on any port.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus: directed rows, then random scans under several register settings.
  initial begin : stimulus
    logic [CFG_W-1:0]   phase_debounce [PHASE_COUNT];
    logic [CFG_W-1:0]   phase_hold     [PHASE_COUNT];
    logic               key_target     [16];
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    logic               raw;
    logic [TIME_W-1:0]  clock_ms;
    int                 pick;

    phase_debounce = '{16'd0, 16'hFFFF, 16'd1, 16'd20, 16'd0, DEBOUNCE_RESET};
    phase_hold     = '{16'd0, 16'hFFFF, 16'd3, 16'd1, 16'd0, HOLD_RESET};
    phase_debounce[4] = CFG_W'($urandom_range(0, 65535));
    phase_hold[4]     = CFG_W'($urandom_range(0, 65535));
    foreach (key_target[i])
      key_target[i] = 1'b0;
    foreach (key_is_down[i]) begin
      key_is_down[i]     = 1'b0;
      last_press_ms[i]   = '0;
      last_release_ms[i] = '0;
      hold_total[i]      = '0;
    end
    clock_ms = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      push_sample(directed_rows[i].row, directed_rows[i].column, directed_rows[i].raw,
                  directed_rows[i].now, directed_rows[i].typed, directed_rows[i].report);
    s_tvalid <= 1'b0;

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_drained();
      // Sender idles lightly first, then the receiver, then neither.
      if (phase < 2) begin
        send_idle_pct = 6;
        take_idle_pct = 64;
      end else if (phase < 4) begin
        send_idle_pct = 64;
        take_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      write_settings(phase_debounce[phase], phase_hold[phase]);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mostly connected keys; now and then any position at all.
        if ($urandom_range(0, 9) == 0) begin
          row    = ROW_W'($urandom_range(0, 3));
          column = COL_W'($urandom_range(0, 3));
        end else begin
          row    = ROW_W'($urandom_range(0, ROWS - 1));
          column = COL_W'($urandom_range(0, COLS - 1));
        end
        // Each key follows a slowly changing level, with contact bounce on top.
        if ($urandom_range(0, 7) == 0)
          key_target[{row, column}] = !key_target[{row, column}];
        raw = !key_target[{row, column}];
        if ($urandom_range(0, 99) < 15)
          raw = 1'($urandom_range(0, 1));
        // Time mostly creeps, sometimes jumps past the debounce window or anywhere.
        pick = $urandom_range(0, 99);
        if (pick < 3)
          clock_ms = $urandom();
        else if (pick < 60)
          clock_ms = clock_ms + $urandom_range(0, 3);
        else if (pick < 90)
          clock_ms = clock_ms + $urandom_range(0, int'(debounce_setting) / 4 + 2);
        else
          clock_ms = clock_ms + $urandom_range(0, 2 * int'(debounce_setting) + 20);
        push_sample(row, column, raw, clock_ms, 1'b0, '0);
      end
      s_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (failures == 0 && pending_reports.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/kmdh_pkg.sv
rtl/key_matrix_debounce_hold.sv
rtl/kmdh_checker.sv
tb/sv/key_matrix_debounce_hold_test.sv
